// File: rtl/dns_answer_ipv4_extractor_top_assert.svh
// assertion macros for the dns answer extractor checker
`ifndef DNS_ANSWER_IPV4_EXTRACTOR_TOP_ASSERT_SVH
`define DNS_ANSWER_IPV4_EXTRACTOR_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define DNSAX_ASSERT_NOW(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("dnsax check failed");

// condition implies consequence in the next cycle
`define DNSAX_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("dnsax check failed");

`endif

// File: rtl/dnsax_pkg.sv
// types and constants shared by the dns answer extractor modules
package dnsax_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_RECHEAD = 2'd1,
        PH_RDATA   = 2'd2,
        PH_IDLE    = 2'd3
    } phase_t;

    localparam logic [1:0] KIND_ADDR     = 2'd0;
    localparam logic [1:0] KIND_NOT_RESP = 2'd1;
    localparam logic [1:0] KIND_DONE     = 2'd2;

    localparam int DNS_HDR_LEN  = 12;
    localparam int QR_OFFSET    = 2;
    localparam int ANC_HI_OFFSET = 6;
    localparam int ANC_LO_OFFSET = 7;

    localparam logic [15:0] REC_HDR_LAST = 16'd11;
    localparam logic [15:0] REC_TYPE_HI  = 16'd2;
    localparam logic [15:0] REC_TYPE_LO  = 16'd3;
    localparam logic [15:0] REC_LEN_HI   = 16'd10;
    localparam logic [15:0] REC_LEN_LO   = 16'd11;
    localparam logic [15:0] ADDR_BYTES   = 16'd4;
    localparam logic [15:0] ADDR_LAST    = 16'd3;
    localparam logic [15:0] TYPE_A       = 16'd1;

    localparam logic [0:0] REG_QLEN = 1'b0;

    localparam int RES_Q_DEPTH = 4;
    localparam int RES_Q_AW    = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [15:0] answer_count;
        logic        run_last;
    } result_t;

    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

endpackage

// File: rtl/dns_answer_ipv4_extractor_top.sv
// top level of the dns answer ipv4 extractor
// a result beat enters the registered result queue when the byte that causes it is accepted
// throughput: one frame byte per cycle while in_ready is high; a byte that gives two results needs two output beats
// input ready drops only while the result queue cannot take two more results
// reset: rst_n asynchronous active low; parser returns to header phase at byte 0,
// question length clears to zero and the result queue empties
module dns_answer_ipv4_extractor_top #(
    parameter int HEADER_OFFSET = 42
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        frame_last,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [31:0] address,
    output logic [15:0] answer_count,
    output logic        run_last,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dnsax_pkg::*;

    logic       room;
    logic       accept;
    logic [7:0] question_length;
    push_t      push;
    result_t    out_res;

    // a beat is taken whenever the queue has room for the worst case of two results
    assign in_ready = room;
    assign accept   = in_valid && in_ready;

    // question length register, read live by the parser on every byte
    dnsax_cfg u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .question_length (question_length)
    );

    // single-pass parse of each accepted byte; state updates at the accept edge
    dnsax_parser #(
        .HEADER_OFFSET (HEADER_OFFSET)
    ) u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .data_byte       (data_byte),
        .frame_last      (frame_last),
        .question_length (question_length),
        .push            (push)
    );

    // registered result queue decouples the output side from the parser
    dnsax_res_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind         = out_res.kind;
    assign address      = out_res.address;
    assign answer_count = out_res.answer_count;
    assign run_last     = out_res.run_last;

endmodule

// File: rtl/dnsax_cfg.sv
// apb register block holding the question length
module dnsax_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  question_length
);
    import dnsax_pkg::*;

    logic [7:0] qlen_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_QLEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg <= 8'd0;
        end
        else if (wr_en)
        begin
            qlen_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_QLEN)
        begin
            prdata = {24'd0, qlen_reg};
        end
    end

    assign question_length = qlen_reg;

endmodule

// File: rtl/dnsax_parser.sv
// per-byte frame parser: walks dns header and answer records
module dnsax_parser #(
    parameter int HEADER_OFFSET = 42
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                frame_last,
    input  logic [7:0]          question_length,
    output dnsax_pkg::push_t    push
);
    import dnsax_pkg::*;

    localparam logic [15:0] QR_POS     = 16'(HEADER_OFFSET + QR_OFFSET);
    localparam logic [15:0] ANC_HI_POS = 16'(HEADER_OFFSET + ANC_HI_OFFSET);
    localparam logic [15:0] ANC_LO_POS = 16'(HEADER_OFFSET + ANC_LO_OFFSET);
    localparam logic [16:0] ANS_BASE   = 17'(HEADER_OFFSET + DNS_HDR_LEN);

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic        resp_reg, resp_next;
    logic [15:0] exp_reg, exp_next;
    logic [15:0] done_reg, done_next;
    logic [15:0] offs_reg, offs_next;
    logic [15:0] rtype_reg, rtype_next;
    logic [15:0] rdlen_reg, rdlen_next;
    logic [31:0] shift_reg, shift_next;

    logic [16:0] ans_start;
    logic [15:0] done_inc;
    logic        finish;
    logic        addr_hit;
    logic        resp_now;
    logic [15:0] exp_now;
    result_t     addr_res;
    result_t     end_res;

    assign ans_start = ANS_BASE + {9'd0, question_length};
    assign done_inc  = done_reg + 16'd1;

    always_comb
    begin
        phase_next = phase_reg;
        resp_next  = resp_reg;
        exp_next   = exp_reg;
        done_next  = done_reg;
        offs_next  = offs_reg;
        rtype_next = rtype_reg;
        rdlen_next = rdlen_reg;
        shift_next = shift_reg;
        finish     = 1'b0;
        addr_hit   = 1'b0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (pos_reg == QR_POS)
                begin
                    resp_next = data_byte[7];
                    if (!data_byte[7])
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                else if (pos_reg == ANC_HI_POS)
                begin
                    exp_next = {data_byte, 8'd0};
                end
                else if (pos_reg == ANC_LO_POS)
                begin
                    exp_next = {exp_reg[15:8], data_byte};
                end
                if ((phase_next == PH_HEADER) && (({1'b0, pos_reg} + 17'd1) >= ans_start))
                begin
                    offs_next  = 16'd0;
                    phase_next = (exp_next != 16'd0) ? PH_RECHEAD : PH_IDLE;
                end
            end
            PH_RECHEAD:
            begin
                priority case (offs_reg)
                    REC_TYPE_HI: rtype_next = {data_byte, 8'd0};
                    REC_TYPE_LO: rtype_next = {rtype_reg[15:8], data_byte};
                    REC_LEN_HI:  rdlen_next = {data_byte, 8'd0};
                    REC_LEN_LO:  rdlen_next = {rdlen_reg[15:8], data_byte};
                    default:     ;
                endcase
                if (offs_reg >= REC_HDR_LAST)
                begin
                    offs_next  = 16'd0;
                    shift_next = 32'd0;
                    if (rdlen_next == 16'd0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_RDATA;
                    end
                end
                else
                begin
                    offs_next = offs_reg + 16'd1;
                end
            end
            PH_RDATA:
            begin
                if (offs_reg < ADDR_BYTES)
                begin
                    shift_next = {shift_reg[23:0], data_byte};
                    addr_hit   = (offs_reg == ADDR_LAST) && (rtype_reg == TYPE_A)
                                 && (rdlen_reg >= ADDR_BYTES);
                end
                if (({1'b0, offs_reg} + 17'd1) >= {1'b0, rdlen_reg})
                begin
                    finish = 1'b1;
                end
                else
                begin
                    offs_next = offs_reg + 16'd1;
                end
            end
            PH_IDLE:
            begin
            end
            default:
            begin
            end
        endcase

        // record complete: count it and pick the next record or stop
        if (finish)
        begin
            done_next  = done_inc;
            offs_next  = 16'd0;
            phase_next = (done_inc >= exp_reg) ? PH_IDLE : PH_RECHEAD;
        end

        pos_next = (pos_reg != 16'hFFFF) ? (pos_reg + 16'd1) : pos_reg;

        // end result reports the frame as parsed through this byte
        resp_now = resp_next;
        exp_now  = exp_next;

        // end of frame returns all per-frame state to reset
        if (frame_last)
        begin
            phase_next = PH_HEADER;
            pos_next   = 16'd0;
            resp_next  = 1'b0;
            exp_next   = 16'd0;
            done_next  = 16'd0;
            offs_next  = 16'd0;
            rtype_next = 16'd0;
            rdlen_next = 16'd0;
            shift_next = 32'd0;
        end
    end

    always_comb
    begin
        addr_res.kind         = KIND_ADDR;
        addr_res.address      = {shift_reg[23:0], data_byte};
        addr_res.answer_count = 16'd0;
        addr_res.run_last     = !frame_last;

        end_res.kind          = resp_now ? KIND_DONE : KIND_NOT_RESP;
        end_res.address       = 32'd0;
        end_res.answer_count  = resp_now ? exp_now : 16'd0;
        end_res.run_last      = 1'b1;

        push.v0 = accept && (addr_hit || frame_last);
        push.r0 = addr_hit ? addr_res : end_res;
        push.v1 = accept && addr_hit && frame_last;
        push.r1 = end_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= 16'd0;
            resp_reg  <= 1'b0;
            exp_reg   <= 16'd0;
            done_reg  <= 16'd0;
            offs_reg  <= 16'd0;
            rtype_reg <= 16'd0;
            rdlen_reg <= 16'd0;
            shift_reg <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            resp_reg  <= resp_next;
            exp_reg   <= exp_next;
            done_reg  <= done_next;
            offs_reg  <= offs_next;
            rtype_reg <= rtype_next;
            rdlen_reg <= rdlen_next;
            shift_reg <= shift_next;
        end
    end

endmodule

// File: rtl/dnsax_res_queue.sv
// small result queue taking up to two results per cycle
module dnsax_res_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  dnsax_pkg::push_t    push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output dnsax_pkg::result_t  out_res
);
    import dnsax_pkg::*;

    localparam logic [RES_Q_AW:0] ROOM_MAX = (RES_Q_AW + 1)'(RES_Q_DEPTH - 2);

    result_t              q_reg [RES_Q_DEPTH];
    logic [RES_Q_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [RES_Q_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [RES_Q_AW:0]    cnt_reg, cnt_next;
    logic [RES_Q_AW-1:0]  wr_ptr_second;
    logic                 pop;
    logic [RES_Q_AW:0]    n_push;

    assign pop           = out_valid && out_ready;
    assign n_push        = (RES_Q_AW + 1)'(push.v0) + (RES_Q_AW + 1)'(push.v1);
    assign wr_ptr_second = wr_ptr_reg + 1'b1;
    assign wr_ptr_next   = wr_ptr_reg + n_push[RES_Q_AW-1:0];
    assign rd_ptr_next   = rd_ptr_reg + RES_Q_AW'(pop);
    assign cnt_next      = cnt_reg + n_push - (RES_Q_AW + 1)'(pop);

    assign room      = (cnt_reg <= ROOM_MAX);
    assign out_valid = (cnt_reg != '0);
    assign out_res   = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            q_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            q_reg[wr_ptr_second] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: rtl/dnsax_checker.sv
// port-level checker for the dns answer extractor, bound to the top level
`include "dns_answer_ipv4_extractor_top_assert.svh"

module dnsax_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [31:0] address,
    input logic [15:0] answer_count,
    input logic        run_last,
    input logic        pready
);
    import dnsax_pkg::*;

    logic [50:0] out_beat;

    assign out_beat = {kind, address, answer_count, run_last};

    `DNSAX_ASSERT_NOW(a_pready_high, 1'b1, pready)
    `DNSAX_ASSERT_NOW(a_kind_legal, out_valid, kind <= KIND_DONE)
    `DNSAX_ASSERT_NOW(a_end_last, out_valid && kind != KIND_ADDR, run_last && address == '0)
    `DNSAX_ASSERT_NOW(a_count_done, out_valid && kind != KIND_DONE, answer_count == '0)
    `DNSAX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat))

endmodule

bind dns_answer_ipv4_extractor_top dnsax_checker u_dnsax_checker (.*);
